>>> rtl/dptd_pkg.sv
// shared constants, types and codes of the drum pad trigger detector
`default_nettype none

package dptd_pkg;

    // sizes
    localparam int NUM_PADS       = 8;
    localparam int PAD_BITS       = 3;
    localparam int SAMPLE_BITS    = 12;
    localparam int THR_BITS       = 12;
    localparam int NOTE_BITS      = 7;
    localparam int VEL_BITS       = 7;
    localparam int TIME_BITS      = 16;
    localparam int SETUP_BITS     = 19;
    localparam int CFG_INDEX_BITS = 4;
    localparam int ATTACK_MS      = 5;

    // setup register layout and reset value (threshold 256, note 36)
    localparam int NOTE_LSB = 12;
    localparam logic [SETUP_BITS-1:0] SETUP_RESET = 19'h24100;

    // velocity rules
    localparam logic [SAMPLE_BITS-1:0] VEL_CLIP_LEVEL = 12'd2047;
    localparam logic [VEL_BITS-1:0]    VEL_MAX        = 7'd127;
    localparam int                     VEL_SHIFT      = 4;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef struct packed {
        logic                   operation;
        logic [PAD_BITS-1:0]    pad_index;
        logic [SAMPLE_BITS-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [PAD_BITS-1:0]  pad_number;
        logic [NOTE_BITS-1:0] note_number;
        logic [VEL_BITS-1:0]  strike_velocity;
        logic                 is_note_on;
    } event_t;

endpackage

`default_nettype wire

>>> rtl/dptd_in_stage.sv
// input register stage holding one word ahead of the pad engine
`default_nettype none

module dptd_in_stage
    import dptd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // room when empty or when the held word leaves this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> rtl/dptd_pad_engine.sv
// per-pad phase machines, setup registers and millisecond counter
`default_nettype none

module dptd_pad_engine
    import dptd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [SETUP_BITS-1:0]     cfg_data,
    input  wire logic                      fire,
    input  wire item_t                     item,
    output logic                           evt_valid,
    output event_t                         evt
);

    logic [SETUP_BITS-1:0]  setup_reg [NUM_PADS];
    phase_t                 phase_reg [NUM_PADS];
    logic [SAMPLE_BITS-1:0] peak_reg  [NUM_PADS];
    logic [TIME_BITS-1:0]   start_reg [NUM_PADS];
    logic [TIME_BITS-1:0]   time_reg;

    logic                   pad_ok;
    logic [THR_BITS-1:0]    thr;
    phase_t                 phase_cur;
    phase_t                 phase_next;
    logic [SAMPLE_BITS-1:0] peak_cur;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [TIME_BITS-1:0]   start_next;
    logic [TIME_BITS-1:0]   elapsed;
    logic [SAMPLE_BITS+2:0] sample_x5;
    logic [SAMPLE_BITS+2:0] thr_x4;
    logic [VEL_BITS-1:0]    vel;
    logic                   state_we;

    // read the addressed pad
    assign pad_ok    = (32'(item.pad_index) < NUM_PADS);
    assign thr       = setup_reg[item.pad_index][THR_BITS-1:0];
    assign phase_cur = phase_reg[item.pad_index];
    assign peak_cur  = peak_reg[item.pad_index];
    assign elapsed   = time_reg - start_reg[item.pad_index];

    // exact form of sample < 0.8 * threshold
    assign sample_x5 = {item.sample_value, 2'b00} + (SAMPLE_BITS+3)'(item.sample_value);
    assign thr_x4    = (SAMPLE_BITS+3)'({thr, 2'b00});

    // next phase and per-pad data
    always_comb
    begin
        phase_next = phase_cur;
        peak_next  = peak_cur;
        start_next = start_reg[item.pad_index];
        case (phase_cur)
            PH_IDLE:
            begin
                if (item.sample_value > thr)
                begin
                    phase_next = PH_ATTACK;
                    peak_next  = item.sample_value;
                    start_next = time_reg;
                end
            end
            PH_ATTACK:
            begin
                if (item.sample_value > peak_cur)
                begin
                    peak_next = item.sample_value;
                end
                if (elapsed >= TIME_BITS'(ATTACK_MS))
                begin
                    phase_next = PH_SUSTAIN;
                end
            end
            PH_SUSTAIN:
            begin
                if (sample_x5 < thr_x4)
                begin
                    phase_next = PH_RELEASE;
                    start_next = time_reg;
                end
            end
            PH_RELEASE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // velocity from the updated peak
    assign vel = (peak_next > VEL_CLIP_LEVEL) ? VEL_MAX : VEL_BITS'(peak_next >> VEL_SHIFT);

    // event output
    always_comb
    begin
        evt.pad_number      = item.pad_index;
        evt.note_number     = setup_reg[item.pad_index][NOTE_LSB +: NOTE_BITS];
        evt.strike_velocity = '0;
        evt.is_note_on      = 1'b0;
        evt_valid           = 1'b0;
        if (item.operation == OP_SAMPLE && pad_ok)
        begin
            if (phase_cur == PH_ATTACK && phase_next == PH_SUSTAIN)
            begin
                evt_valid           = 1'b1;
                evt.is_note_on      = 1'b1;
                evt.strike_velocity = vel;
            end
            else if (phase_cur == PH_RELEASE)
            begin
                evt_valid = 1'b1;
            end
        end
    end

    assign state_we = fire && item.operation == OP_SAMPLE && pad_ok;

    // pad state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PADS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                peak_reg[i]  <= '0;
                start_reg[i] <= '0;
            end
        end
        else if (state_we)
        begin
            phase_reg[item.pad_index] <= phase_next;
            peak_reg[item.pad_index]  <= peak_next;
            start_reg[item.pad_index] <= start_next;
        end
    end

    // millisecond counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (fire && item.operation == OP_TICK)
        begin
            time_reg <= time_reg + 1'b1;
        end
    end

    // setup registers, out-of-range indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PADS; i++)
            begin
                setup_reg[i] <= SETUP_RESET;
            end
        end
        else if (cfg_write && 32'(cfg_index) < NUM_PADS)
        begin
            setup_reg[cfg_index[PAD_BITS-1:0]] <= cfg_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/drum_pad_trigger_detector_core.sv
// top level of the eight-pad drum trigger detector
//
// Input channel (in_valid/in_ready) carries one word per item: a converter
// sample for one pad (operation = sample) or a one millisecond tick.
// Output channel (out_valid/out_ready) carries note-on and note-off events;
// an item makes zero or one event.
// Configuration: cfg_write with cfg_index and cfg_data writes one pad setup
// register (threshold in bits 11:0, note in bits 18:12) in the same cycle;
// indexes 8 and up are dropped. Write only while the block is idle.
// Path: an accepted word is registered in the input stage, processed by the pad
// engine once the output register can take its event, and its event is loaded
// into the output register, whose valid bit drives out_valid.
// Throughput: one word per cycle unless the output stalls, any pad order;
// per-pad state is read and rewritten per word, so a pad may repeat back to back.
// Stall: when out_ready is low with an event waiting, the held input word
// and then in_ready stall; an input word is still taken while the output
// register holds an event, as long as the input register is free.
// Reset: all pads idle, time counter zero, setups at threshold 256, note 36.
`default_nettype none

module drum_pad_trigger_detector_core
    import dptd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      operation,
    input  wire logic [PAD_BITS-1:0]       pad_index,
    input  wire logic [SAMPLE_BITS-1:0]    sample_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [PAD_BITS-1:0]            pad_number,
    output logic [NOTE_BITS-1:0]           note_number,
    output logic [VEL_BITS-1:0]            strike_velocity,
    output logic                           is_note_on,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [SETUP_BITS-1:0]     cfg_data
);

    item_t  in_item;
    item_t  item;
    logic   item_valid;
    logic   fire;
    logic   evt_valid;
    event_t evt;
    logic   out_valid_reg;
    logic   out_valid_next;
    event_t out_reg;

    assign in_item.operation    = operation;
    assign in_item.pad_index    = pad_index;
    assign in_item.sample_value = sample_value;

    // process the held word when the output register can take its event
    assign fire = item_valid && (!out_valid_reg || out_ready);

    dptd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    dptd_pad_engine u_pad_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = evt_valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (fire && evt_valid)
        begin
            out_reg <= evt;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pad_number      = out_reg.pad_number;
    assign note_number     = out_reg.note_number;
    assign strike_velocity = out_reg.strike_velocity;
    assign is_note_on      = out_reg.is_note_on;

    // note-off words never carry a velocity
    a_off_zero_vel : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_note_on |-> strike_velocity == '0)
        else $error("note-off word with nonzero velocity");

    // input side only stalls behind a blocked output register
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid && out_valid_reg && !out_ready)
        else $error("input stalled without an output stall");

    // a processed tick leaves no event behind
    a_tick_silent : assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_TICK |=> !out_valid)
        else $error("tick produced an event");

endmodule

`default_nettype wire

>>> sim/drum_pad_trigger_detector_core_test.sv
// self-checking testbench for the eight-pad drum trigger detector core
`timescale 1ns / 100ps

module drum_pad_trigger_detector_core_test;
    import dptd_pkg::*;

    localparam int              PIPE_SLACK   = 4;
    localparam int              CFG_LAST_IDX = 2**CFG_INDEX_BITS - 1;
    localparam logic [TIME_BITS-1:0] WRAP_START = 16'd65533;
    localparam int              MAX_REPORTS  = 40;
    localparam int              PHASE_WORDS  = 380;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      operation = 1'b0;
    logic [PAD_BITS-1:0]       pad_index = '0;
    logic [SAMPLE_BITS-1:0]    sample_value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [PAD_BITS-1:0]       pad_number;
    logic [NOTE_BITS-1:0]      note_number;
    logic [VEL_BITS-1:0]       strike_velocity;
    logic                      is_note_on;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [SETUP_BITS-1:0]     cfg_data = '0;

    // predicted pad machines and setups
    logic [SETUP_BITS-1:0]  pad_setup [NUM_PADS];
    phase_t                 pad_state [NUM_PADS];
    logic [SAMPLE_BITS-1:0] pad_top   [NUM_PADS];
    logic [TIME_BITS-1:0]   strike_ms [NUM_PADS];
    logic [TIME_BITS-1:0]   clock_ms;

    // stimulus planning per pad
    phase_t                 plan      [NUM_PADS];
    logic [TIME_BITS-1:0]   plan_ms   [NUM_PADS];
    logic [TIME_BITS-1:0]   gen_ms;
    logic [SETUP_BITS-1:0]  next_setup [NUM_PADS];

    item_t       word_backlog [$];
    event_t      note_events [$];
    int          words_left = 0;
    int          errors = 0;
    bit          rush = 1'b0;

    item_t       held_word;
    bit          word_held = 1'b0;
    int unsigned drv_wait = 0;
    int unsigned drv_calm = 0;
    int unsigned mon_wait = 0;
    int unsigned mon_calm = 0;

    drum_pad_trigger_detector_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .pad_index       (pad_index),
        .sample_value    (sample_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pad_number      (pad_number),
        .note_number     (note_number),
        .strike_velocity (strike_velocity),
        .is_note_on      (is_note_on),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("drum_pad_trigger_detector_core_test: done, errors");
        $finish;
    end

    // random pause: mostly none or short, a few long, with calm stretches
    function automatic int unsigned pause_len(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(40, 160);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // pad machine: advance on one word, return 1 with the note event it makes
    function automatic bit pad_machine_step(input item_t w, output event_t ev);
        logic [THR_BITS-1:0]  thr;
        logic [TIME_BITS-1:0] elapsed;
        int unsigned          p;
        bit                   hit;
        hit = 1'b0;
        ev  = '0;
        if (w.operation == OP_TICK)
        begin
            clock_ms = clock_ms + 1'b1;
            return 1'b0;
        end
        p   = w.pad_index;
        thr = pad_setup[p][THR_BITS-1:0];
        ev.pad_number  = w.pad_index;
        ev.note_number = pad_setup[p][NOTE_LSB +: NOTE_BITS];
        case (pad_state[p])
            PH_IDLE:
            begin
                if (w.sample_value > thr)
                begin
                    pad_state[p] = PH_ATTACK;
                    pad_top[p]   = w.sample_value;
                    strike_ms[p] = clock_ms;
                end
            end
            PH_ATTACK:
            begin
                if (w.sample_value > pad_top[p])
                    pad_top[p] = w.sample_value;
                elapsed = clock_ms - strike_ms[p];
                if (elapsed >= ATTACK_MS)
                begin
                    ev.strike_velocity = (pad_top[p] > VEL_CLIP_LEVEL) ? VEL_MAX
                                         : VEL_BITS'(pad_top[p] >> VEL_SHIFT);
                    ev.is_note_on = 1'b1;
                    pad_state[p]  = PH_SUSTAIN;
                    hit = 1'b1;
                end
            end
            PH_SUSTAIN:
            begin
                // 0.8 of threshold, tested exactly
                if (int'(w.sample_value) * 5 < int'(thr) * 4)
                begin
                    pad_state[p] = PH_RELEASE;
                    strike_ms[p] = clock_ms;
                end
            end
            default:
            begin
                // any sample ends release, no threshold test
                ev.strike_velocity = '0;
                ev.is_note_on      = 1'b0;
                pad_state[p]       = PH_IDLE;
                hit = 1'b1;
            end
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS)
            $display("mismatch @%0t: %s", $time, what);
        errors++;
    endtask

    task automatic push_word(input logic op, input int unsigned pad, input int unsigned s);
        item_t w;
        w.operation    = op;
        w.pad_index    = PAD_BITS'(pad);
        w.sample_value = SAMPLE_BITS'(s);
        if (op == OP_TICK)
            gen_ms = gen_ms + 1'b1;
        word_backlog.push_back(w);
        words_left++;
    endtask

    // random words, mostly steering each pad through a full stroke
    task automatic add_strokes(input int count, input int unsigned tick_pct);
        int unsigned          p;
        int unsigned          s;
        int unsigned          thr;
        int unsigned          low;
        logic [TIME_BITS-1:0] span;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                push_word(OP_TICK, $urandom_range(0, NUM_PADS - 1), $urandom_range(0, 4095));
            else if ($urandom_range(0, 99) < 5)
                push_word(OP_SAMPLE, $urandom_range(0, NUM_PADS - 1), $urandom_range(0, 4095));
            else
            begin
                p   = $urandom_range(0, NUM_PADS - 1);
                thr = pad_setup[p][THR_BITS-1:0];
                case (plan[p])
                    PH_IDLE:
                    begin
                        if (thr == 4095 || $urandom_range(0, 5) == 0)
                            s = $urandom_range(0, thr);
                        else
                        begin
                            s = $urandom_range(thr + 1, 4095);
                            plan[p]    = PH_ATTACK;
                            plan_ms[p] = gen_ms;
                        end
                    end
                    PH_ATTACK:
                    begin
                        s    = $urandom_range(0, 4095);
                        span = gen_ms - plan_ms[p];
                        if (span >= ATTACK_MS)
                            plan[p] = PH_SUSTAIN;
                    end
                    PH_SUSTAIN:
                    begin
                        low = (4 * thr + 4) / 5;
                        if (low > 0 && $urandom_range(0, 9) < 3)
                        begin
                            s = $urandom_range(0, low - 1);
                            plan[p] = PH_RELEASE;
                        end
                        else
                            s = $urandom_range(low, 4095);
                    end
                    default:
                    begin
                        s = $urandom_range(0, 4095);
                        plan[p] = PH_IDLE;
                    end
                endcase
                push_word(OP_SAMPLE, p, s);
            end
        end
    endtask

    // write all pad setups, then one write to a spare index that must be dropped
    task automatic load_setups();
        for (int p = 0; p < NUM_PADS; p++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(p);
            cfg_data  <= next_setup[p];
            pad_setup[p] = next_setup[p];
        end
        @(posedge clk);
        cfg_index <= CFG_INDEX_BITS'($urandom_range(NUM_PADS, CFG_LAST_IDX));
        cfg_data  <= SETUP_BITS'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every word is taken and every event has come back
    task automatic settle();
        while (words_left != 0 || note_events.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
        @(negedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                event_t ev;
                if (pad_machine_step(held_word, ev))
                    note_events.push_back(ev);
                words_left--;
                word_held = 1'b0;
            end
            if (!word_held)
            begin
                if (drv_wait != 0)
                    drv_wait--;
                else if (word_backlog.size() != 0)
                begin
                    held_word = word_backlog.pop_front();
                    word_held = 1'b1;
                    drv_wait  = rush ? 0 : pause_len(drv_calm);
                end
            end
            in_valid     <= word_held;
            operation    <= held_word.operation;
            pad_index    <= held_word.pad_index;
            sample_value <= held_word.sample_value;
        end
    end

    // output monitor and random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                event_t want;
                if (note_events.size() == 0)
                    report_mismatch($sformatf("unexpected event pad %0d note %0d vel %0d on %0b",
                                              pad_number, note_number, strike_velocity,
                                              is_note_on));
                else
                begin
                    want = note_events.pop_front();
                    if (pad_number !== want.pad_number)
                        report_mismatch($sformatf("pad_number %0d, want %0d",
                                                  pad_number, want.pad_number));
                    if (note_number !== want.note_number)
                        report_mismatch($sformatf("note_number %0d, want %0d",
                                                  note_number, want.note_number));
                    if (strike_velocity !== want.strike_velocity)
                        report_mismatch($sformatf("strike_velocity %0d, want %0d",
                                                  strike_velocity, want.strike_velocity));
                    if (is_note_on !== want.is_note_on)
                        report_mismatch($sformatf("is_note_on %0b, want %0b",
                                                  is_note_on, want.is_note_on));
                end
                mon_wait = pause_len(mon_calm);
            end
            else if (mon_wait != 0)
                mon_wait--;
            else if ($urandom_range(0, 15) == 0)
                mon_wait = pause_len(mon_calm);
            out_ready <= (mon_wait == 0);
        end
    end

    // stimulus and phases
    initial
    begin
        int unsigned r;
        int unsigned thr;
        int          wrap_ticks;
        for (int p = 0; p < NUM_PADS; p++)
        begin
            pad_setup[p] = SETUP_RESET;
            pad_state[p] = PH_IDLE;
            pad_top[p]   = '0;
            strike_ms[p] = '0;
            plan[p]      = PH_IDLE;
            plan_ms[p]   = '0;
        end
        clock_ms = '0;
        gen_ms   = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setups: threshold edges, clipped peak, full stroke on pad 0
        push_word(OP_SAMPLE, 0, 0);
        push_word(OP_SAMPLE, 0, 256);
        push_word(OP_SAMPLE, 0, 257);
        push_word(OP_SAMPLE, 0, 4095);
        repeat (4) push_word(OP_TICK, 0, 0);
        push_word(OP_SAMPLE, 0, 100);
        push_word(OP_TICK, 7, 4095);
        push_word(OP_SAMPLE, 0, 0);
        push_word(OP_SAMPLE, 0, 205);
        push_word(OP_SAMPLE, 0, 204);
        push_word(OP_SAMPLE, 0, 4095);
        // velocity at the clip level (not clipped) and a plain shifted one
        push_word(OP_SAMPLE, 7, 2047);
        push_word(OP_SAMPLE, 1, 300);
        repeat (5) push_word(OP_TICK, 0, 0);
        push_word(OP_SAMPLE, 7, 0);
        push_word(OP_SAMPLE, 1, 0);
        plan[1] = PH_SUSTAIN;
        plan[7] = PH_SUSTAIN;
        settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            for (int p = 0; p < NUM_PADS; p++)
            begin
                r = $urandom_range(0, 99);
                if (ph == 4)
                    thr = $urandom_range(0, 40);
                else if (r < 70)
                    thr = $urandom_range(64, 2000);
                else if (r < 85)
                    thr = $urandom_range(2000, 4000);
                else
                    thr = $urandom_range(0, 4095);
                next_setup[p] = {NOTE_BITS'($urandom), THR_BITS'(thr)};
            end
            if (ph == 0)
            begin
                // full-scale threshold with top note, zero threshold with note zero
                next_setup[0] = '1;
                next_setup[3] = '0;
            end
            load_setups();
            if (ph == 0)
            begin
                push_word(OP_SAMPLE, 0, 4095);
                push_word(OP_SAMPLE, 3, 0);
                push_word(OP_SAMPLE, 3, 1);
                plan[3]    = PH_ATTACK;
                plan_ms[3] = gen_ms;
            end
            add_strokes(PHASE_WORDS, 10);
            settle();
        end

        // time counter wrap during an attack
        for (int p = 0; p < NUM_PADS; p++)
            next_setup[p] = {NOTE_BITS'($urandom), THR_BITS'($urandom_range(1, 3000))};
        load_setups();
        // bring every pad back to idle
        repeat (ATTACK_MS) push_word(OP_TICK, 0, 0);
        for (int p = 0; p < NUM_PADS; p++)
        begin
            repeat (4) push_word(OP_SAMPLE, p, 0);
            plan[p] = PH_IDLE;
        end
        settle();
        rush = 1'b1;
        wrap_ticks = int'(TIME_BITS'(WRAP_START - clock_ms));
        repeat (wrap_ticks) push_word(OP_TICK, 0, 0);
        while (words_left != 0)
            @(posedge clk);
        rush = 1'b0;
        @(negedge clk);
        for (int p = 0; p < NUM_PADS; p++)
        begin
            push_word(OP_SAMPLE, p, 4095);
            plan[p]    = PH_ATTACK;
            plan_ms[p] = gen_ms;
        end
        add_strokes(150, 20);
        settle();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("drum_pad_trigger_detector_core_test: done, clean");
        else
            $display("drum_pad_trigger_detector_core_test: done, errors");
        $finish;
    end

endmodule
